// File: rtl/core/pkxsc_pkg.sv
// Shared types and constants for the passphrase-keyed XOR stream cipher.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package pkxsc_pkg;

    localparam int KEY_BYTES = 16;
    localparam int POS_W     = 4;
    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 2;

    typedef logic [BYTE_W-1:0] byte_val_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [KEY_BYTES-1:0][BYTE_W-1:0] key_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 2'd0,
        CMD_ABSORB = 2'd1,
        CMD_KEY    = 2'd2,
        CMD_DATA   = 2'd3
    } cmd_t;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // Master key value after reset and after every start command, entry 15 first.
    localparam key_t INIT_KEY = {
        8'h00, 8'hFE, 8'hDC, 8'hBA, 8'h98, 8'h75, 8'h54, 8'h32,
        8'h10, 8'hEF, 8'hCD, 8'hAB, 8'h89, 8'h57, 8'h45, 8'h01
    };

    // One request leaving the input register for processing in this cycle.
    typedef struct packed {
        logic      valid;
        cmd_t      cmd;
        byte_val_t data;
    } step_t;

    // The result a request produces, if any.
    typedef struct packed {
        logic      valid;
        byte_val_t value;
        logic      kind;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/core/pkxsc_req_if.sv
// Request channel of the cipher: command and byte with a valid/ready handshake.
// Depends on pkxsc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pkxsc_req_if;
    logic                         valid;
    logic                         ready;
    logic [pkxsc_pkg::CMD_W-1:0]  command;
    logic [pkxsc_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink (input valid, input command, input data_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pkxsc_res_if.sv
// Result channel of the cipher: output byte and its kind with a valid/ready handshake.
// Depends on pkxsc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pkxsc_res_if;
    logic                         valid;
    logic                         ready;
    logic [pkxsc_pkg::BYTE_W-1:0] out_byte;
    logic                         out_kind;

    modport source (output valid, output out_byte, output out_kind, input ready);
    modport sink (input valid, input out_byte, input out_kind, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pkxsc_master_key.sv
// Master key register file with the passphrase absorb update and its position.
// Depends on pkxsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pkxsc_master_key (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pkxsc_pkg::step_t   step,
    input  wire pkxsc_pkg::pos_t    key_idx,
    output pkxsc_pkg::byte_val_t    key_byte
);
    import pkxsc_pkg::*;

    key_t  key_reg;
    key_t  key_next;
    pos_t  pos_reg;
    pos_t  pos_next;
    pos_t  nx;
    pos_t  pv;
    logic [2*BYTE_W-1:0] prod;

    // Byte used by the key load path; the entry is selected by the load position.
    assign key_byte = key_reg[key_idx];

    always_comb
    begin
        nx       = pos_reg + pos_t'(1);
        pv       = pos_reg - pos_t'(1);
        prod     = {{BYTE_W{1'b0}}, key_reg[pv]} * {{BYTE_W{1'b0}}, step.data};
        key_next = key_reg;
        pos_next = pos_reg;
        if (step.valid)
        begin
            case (step.cmd)
                CMD_START:
                begin
                    key_next = INIT_KEY;
                    pos_next = '0;
                end
                CMD_ABSORB:
                begin
                    // The three touched entries are always distinct.
                    key_next[pos_reg] = key_reg[pos_reg] ^ step.data;
                    key_next[nx]      = key_reg[nx] + step.data;
                    key_next[pv]      = prod[BYTE_W-1:0];
                    pos_next          = nx;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= INIT_KEY;
            pos_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pkxsc_file_key.sv
// File key store with its load and stream positions, and the result byte logic.
// Depends on pkxsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pkxsc_sess_key (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pkxsc_pkg::step_t     step,
    input  wire logic                 direction,
    input  wire pkxsc_pkg::byte_val_t master_byte,
    output pkxsc_pkg::pos_t           load_idx,
    output pkxsc_pkg::res_t           res
);
    import pkxsc_pkg::*;

    byte_val_t sess_key_reg [KEY_BYTES];
    byte_val_t sess_key_next;
    logic      sess_key_we;
    pos_t      load_pos_reg;
    pos_t      load_pos_next;
    pos_t      stream_pos_reg;
    pos_t      stream_pos_next;

    assign load_idx = load_pos_reg;

    always_comb
    begin
        sess_key_we     = 1'b0;
        sess_key_next   = step.data;
        load_pos_next   = load_pos_reg;
        stream_pos_next = stream_pos_reg;
        res.valid       = 1'b0;
        res.value       = step.data ^ master_byte;
        res.kind        = KIND_HEADER;
        if (step.valid)
        begin
            case (step.cmd)
                CMD_START:
                begin
                    load_pos_next   = '0;
                    stream_pos_next = '0;
                end
                CMD_KEY:
                begin
                    // Encrypt stores the plain key and sends the masked header;
                    // decrypt unmasks the header and sends nothing.
                    sess_key_we   = 1'b1;
                    load_pos_next = load_pos_reg + pos_t'(1);
                    if (direction == DIR_ENCRYPT)
                    begin
                        res.valid = 1'b1;
                    end
                    else
                    begin
                        sess_key_next = step.data ^ master_byte;
                    end
                end
                CMD_DATA:
                begin
                    res.valid       = 1'b1;
                    res.value       = step.data ^ sess_key_reg[stream_pos_reg];
                    res.kind        = KIND_DATA;
                    stream_pos_next = stream_pos_reg + pos_t'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Key bytes hold no reset value; an entry is valid once it has been loaded.
    always_ff @(posedge clk)
    begin
        if (sess_key_we)
        begin
            sess_key_reg[load_pos_reg] <= sess_key_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg   <= '0;
            stream_pos_reg <= '0;
        end
        else
        begin
            load_pos_reg   <= load_pos_next;
            stream_pos_reg <= stream_pos_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/passphrase_key_xor_stream_cipher.sv
// Top level of the passphrase-keyed XOR stream cipher: input register, key state,
// file key logic and result register. Depends on pkxsc_pkg, pkxsc_req_if,
// pkxsc_res_if, pkxsc_master_key and pkxsc_sess_key.
//
//   Channel   Role    Payload                     Moves
//   request   sink    command[1:0], data_byte[7:0] one command byte per request
//   result    source  out_byte[7:0], out_kind      zero or one result per request
//   cfg       write   cfg_data (direction)         one bit, taken when cfg_we is high
//
// A request is registered on acceptance and processed from the input register; its
// result, if any, is registered and appears on the result channel. One request per
// cycle is sustained while the result channel is not stalled: the state update is a
// single pass through the key registers and one 8 by 8 multiplier. Reset (rst_n,
// asynchronous, active low) loads the master key init table, clears all positions and
// selects encrypt. When the result register is full and not taken, the input register
// holds its request and request.ready drops once it is also full.
`timescale 1ns / 1ps
`default_nettype none

module passphrase_key_xor_stream_cipher (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_data,
    pkxsc_req_if.sink request,
    pkxsc_res_if.source result
);
    import pkxsc_pkg::*;

    // Configuration: the direction bit; the user writes it only while the block is idle, not enforced here.
    logic direction_reg;

    // Input register holding one accepted request.
    logic      in_valid_reg;
    logic      in_valid_next;
    cmd_t      in_cmd_reg;
    byte_val_t in_data_reg;

    // Result register driving the result channel.
    logic      out_valid_reg;
    logic      out_valid_next;
    byte_val_t out_byte_reg;
    logic      out_kind_reg;

    logic      advance;
    logic      fire;
    step_t     step;
    res_t      res;
    pos_t      load_idx;
    byte_val_t master_byte;

    // The request in the input register moves on whenever the result register can
    // take what it produces; a request with no result still waits behind a stalled
    // result so that ordering and state updates stay simple.
    assign advance       = !out_valid_reg || result.ready;
    assign fire          = in_valid_reg && advance;
    assign request.ready = !in_valid_reg || advance;

    assign step.valid = fire;
    assign step.cmd   = in_cmd_reg;
    assign step.data  = in_data_reg;

    pkxsc_master_key u_master_key (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .key_idx  (load_idx),
        .key_byte (master_byte)
    );

    pkxsc_sess_key u_sess_key (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .direction   (direction_reg),
        .master_byte (master_byte),
        .load_idx    (load_idx),
        .res         (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (request.valid && request.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_ENCRYPT;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                direction_reg <= cfg_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            in_cmd_reg  <= cmd_t'(request.command);
            in_data_reg <= request.data_byte;
        end
        if (advance && res.valid)
        begin
            out_byte_reg <= res.value;
            out_kind_reg <= res.kind;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.out_kind = out_kind_reg;

    // A stalled result must block processing of the next request.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !fire)
        else $error("request processed while result register is stalled");

    // A request held in the input register keeps its command until it is processed.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_cmd_reg)))
        else $error("held request lost or changed");

    // A data byte always yields a data result in the next cycle.
    a_data_result: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_cmd_reg == CMD_DATA) |=> (out_valid_reg && out_kind_reg == KIND_DATA))
        else $error("data byte did not produce a data result");

    // A header byte in decrypt mode produces nothing.
    a_decrypt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_cmd_reg == CMD_KEY && direction_reg == DIR_DECRYPT) |=> !out_valid_reg)
        else $error("decrypt key byte produced a result");

endmodule

`default_nettype wire
